[rtl/vxe_pkg.sv]
package vxe_pkg;

  localparam int unsigned MAX_INNER_LEN = 1500;
  localparam int unsigned HDR_BYTES     = 50;
  localparam int unsigned INNER_HEAD    = 14;
  localparam int unsigned BURST_BYTES   = HDR_BYTES + INNER_HEAD;
  localparam int unsigned WINDOW_DEPTH  = 18;

  localparam logic [10:0] MIN_LEN       = 11'd14;
  localparam logic [10:0] MAX_LEN       = 11'(MAX_INNER_LEN);
  localparam logic [10:0] TAG_MIN_LEN   = 11'd18;
  localparam logic [10:0] TAG_BYTES     = 11'd4;
  localparam logic [10:0] COUNT_MAX     = 11'd2047;

  localparam logic [7:0]  BCAST_BYTE    = 8'hff;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TTL        = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [7:0]  VXLAN_FLAGS   = 8'h08;
  localparam logic [7:0]  TPID_HI       = 8'h81;
  localparam logic [7:0]  TPID_LO       = 8'h00;
  localparam logic [15:0] IP_HDR_OVER   = 16'd36;
  localparam logic [15:0] UDP_HDR_OVER  = 16'd16;
  localparam logic [1:0]  SRC_PORT_TOP  = 2'b11;
  localparam logic [15:0] CSUM_CONST    = {IP_VER_IHL, 8'h00} + {IP_TTL, IP_PROTO_UDP};

  localparam logic [15:0] UDP_PORT_RST  = 16'd4789;

  typedef enum logic [2:0] {
    CFG_SRC_MAC    = 3'd0,
    CFG_SRC_IP     = 3'd1,
    CFG_UDP_PORT   = 3'd2,
    CFG_NET_ID     = 3'd3,
    CFG_STRIP_VLAN = 3'd4
  } cfg_idx_t;

endpackage

[rtl/vxlan_frame_encapsulator_unit.sv]
// Output is registered. Throughput: one byte per cycle while forwarding and
// the output is not stalled; the byte that completes the inner Ethernet header
// starts a 64-byte burst (50-byte outer header plus 14 inner header bytes),
// during which the input is stalled.
// Reset: synchronous, active high; clears frame tracking, output valid and the
// burst, and loads configuration defaults.
module vxlan_frame_encapsulator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic [10:0] frame_len,
  input  logic [31:0] remote_ip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_error
);

  logic [47:0] src_mac;
  logic [31:0] src_ip;
  logic [15:0] udp_dest_port;
  logic [23:0] net_id;
  logic        strip_vlan;

  logic [10:0] byte_count, byte_count_next;
  logic        tagged_strip, tagged_strip_next;
  logic        length_bad, length_bad_next;
  logic [10:0] held_len, held_len_next;
  logic [31:0] held_remote_ip, held_remote_ip_next;
  logic [7:0]  head_window [vxe_pkg::WINDOW_DEPTH];

  logic        burst_active;
  logic [5:0]  burst_idx;
  logic [10:0] burst_len;
  logic [15:0] burst_csum;
  logic [15:0] burst_sport;
  logic        burst_last;
  logic        burst_tag;

  logic        out_free, accept;
  logic        hw_we, burst_go;
  logic        res_valid, res_last, res_error;
  logic [7:0]  res_byte;
  logic        len_ok, tag_hit;

  logic [10:0] len_now;
  logic [15:0] iptot_now;
  logic [18:0] sum0;
  logic [16:0] sum1;
  logic [15:0] sum2;
  logic [7:0]  mac_xor, inner12_now;
  logic [15:0] iptot_b, udplen_b;
  logic [7:0]  hdr_byte;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = burst_active || !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_mac       <= '0;
      src_ip        <= '0;
      udp_dest_port <= vxe_pkg::UDP_PORT_RST;
      net_id        <= '0;
      strip_vlan    <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vxe_pkg::CFG_SRC_MAC:    src_mac       <= cfg_data;
        vxe_pkg::CFG_SRC_IP:     src_ip        <= cfg_data[31:0];
        vxe_pkg::CFG_UDP_PORT:   udp_dest_port <= cfg_data[15:0];
        vxe_pkg::CFG_NET_ID:     net_id        <= cfg_data[23:0];
        vxe_pkg::CFG_STRIP_VLAN: strip_vlan    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign len_ok  = (frame_len >= vxe_pkg::MIN_LEN) && (frame_len <= vxe_pkg::MAX_LEN);
  assign tag_hit = strip_vlan && (head_window[12] == vxe_pkg::TPID_HI) &&
                   (in_byte == vxe_pkg::TPID_LO) && (held_len >= vxe_pkg::TAG_MIN_LEN);

  always_comb begin
    byte_count_next     = byte_count;
    tagged_strip_next   = tagged_strip;
    length_bad_next     = length_bad;
    held_len_next       = held_len;
    held_remote_ip_next = held_remote_ip;
    hw_we     = 1'b0;
    burst_go  = 1'b0;
    res_valid = 1'b0;
    res_byte  = in_byte;
    res_last  = in_last;
    res_error = 1'b0;
    if (accept) begin
      if (length_bad) begin
        if (in_last) begin
          byte_count_next   = '0;
          tagged_strip_next = 1'b0;
          length_bad_next   = 1'b0;
        end
      end else begin
        if (byte_count == '0) begin
          held_len_next       = frame_len;
          held_remote_ip_next = remote_ip;
          tagged_strip_next   = 1'b0;
        end
        if ((byte_count == '0) && !len_ok) begin
          res_valid       = 1'b1;
          res_error       = 1'b1;
          byte_count_next = '0;
          length_bad_next = !in_last;
        end else begin
          hw_we = byte_count < 11'(vxe_pkg::WINDOW_DEPTH);
          priority if ((byte_count < 11'd13) ||
                       ((byte_count == 11'd13) && tag_hit) ||
                       (tagged_strip && (byte_count < 11'd17))) begin
            if ((byte_count == 11'd13) && tag_hit) tagged_strip_next = 1'b1;
            if (in_last) begin
              res_valid         = 1'b1;
              res_error         = 1'b1;
              byte_count_next   = '0;
              tagged_strip_next = 1'b0;
            end else begin
              byte_count_next = byte_count + 11'd1;
            end
          end else if ((byte_count == 11'd13) || (tagged_strip && (byte_count == 11'd17))) begin
            burst_go  = 1'b1;
            res_valid = 1'b1;
            if (in_last) begin
              byte_count_next   = '0;
              tagged_strip_next = 1'b0;
            end else begin
              byte_count_next = byte_count + 11'd1;
            end
          end else begin
            res_valid = 1'b1;
            if (in_last) begin
              byte_count_next   = '0;
              tagged_strip_next = 1'b0;
            end else if (byte_count != vxe_pkg::COUNT_MAX) begin
              byte_count_next = byte_count + 11'd1;
            end
          end
        end
      end
    end
    if (res_error) begin
      res_byte = '0;
      res_last = 1'b0;
    end
  end

  assign len_now   = tagged_strip ? (held_len - vxe_pkg::TAG_BYTES) : held_len;
  assign iptot_now = 16'(len_now) + vxe_pkg::IP_HDR_OVER;
  assign sum0 = 19'(vxe_pkg::CSUM_CONST) + 19'(iptot_now) + 19'(src_ip[31:16]) +
                19'(src_ip[15:0]) + 19'(held_remote_ip[31:16]) +
                19'(held_remote_ip[15:0]);
  assign sum1 = 17'(sum0[15:0]) + 17'(sum0[18:16]);
  assign sum2 = sum1[15:0] + 16'(sum1[16]);

  assign mac_xor = head_window[0] ^ head_window[1] ^ head_window[2] ^ head_window[3] ^
                   head_window[4] ^ head_window[5] ^ head_window[6] ^ head_window[7] ^
                   head_window[8] ^ head_window[9] ^ head_window[10] ^ head_window[11];
  assign inner12_now = tagged_strip ? head_window[16] : head_window[12];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      tagged_strip   <= 1'b0;
      length_bad     <= 1'b0;
      held_len       <= '0;
      held_remote_ip <= '0;
    end else begin
      byte_count     <= byte_count_next;
      tagged_strip   <= tagged_strip_next;
      length_bad     <= length_bad_next;
      held_len       <= held_len_next;
      held_remote_ip <= held_remote_ip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hw_we) head_window[byte_count[4:0]] <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (burst_go) begin
      burst_len   <= len_now;
      burst_csum  <= ~sum2;
      burst_sport <= {vxe_pkg::SRC_PORT_TOP, inner12_now[5:0], in_byte ^ mac_xor};
      burst_last  <= in_last;
      burst_tag   <= tagged_strip;
    end
  end

  assign iptot_b  = 16'(burst_len) + vxe_pkg::IP_HDR_OVER;
  assign udplen_b = 16'(burst_len) + vxe_pkg::UDP_HDR_OVER;

  always_comb begin
    unique case (burst_idx)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: hdr_byte = vxe_pkg::BCAST_BYTE;
      6'd6:  hdr_byte = src_mac[47:40];
      6'd7:  hdr_byte = src_mac[39:32];
      6'd8:  hdr_byte = src_mac[31:24];
      6'd9:  hdr_byte = src_mac[23:16];
      6'd10: hdr_byte = src_mac[15:8];
      6'd11: hdr_byte = src_mac[7:0];
      6'd12: hdr_byte = vxe_pkg::ETH_TYPE_IPV4[15:8];
      6'd13: hdr_byte = vxe_pkg::ETH_TYPE_IPV4[7:0];
      6'd14: hdr_byte = vxe_pkg::IP_VER_IHL;
      6'd16: hdr_byte = iptot_b[15:8];
      6'd17: hdr_byte = iptot_b[7:0];
      6'd22: hdr_byte = vxe_pkg::IP_TTL;
      6'd23: hdr_byte = vxe_pkg::IP_PROTO_UDP;
      6'd24: hdr_byte = burst_csum[15:8];
      6'd25: hdr_byte = burst_csum[7:0];
      6'd26: hdr_byte = src_ip[31:24];
      6'd27: hdr_byte = src_ip[23:16];
      6'd28: hdr_byte = src_ip[15:8];
      6'd29: hdr_byte = src_ip[7:0];
      6'd30: hdr_byte = held_remote_ip[31:24];
      6'd31: hdr_byte = held_remote_ip[23:16];
      6'd32: hdr_byte = held_remote_ip[15:8];
      6'd33: hdr_byte = held_remote_ip[7:0];
      6'd34: hdr_byte = burst_sport[15:8];
      6'd35: hdr_byte = burst_sport[7:0];
      6'd36: hdr_byte = udp_dest_port[15:8];
      6'd37: hdr_byte = udp_dest_port[7:0];
      6'd38: hdr_byte = udplen_b[15:8];
      6'd39: hdr_byte = udplen_b[7:0];
      6'd42: hdr_byte = vxe_pkg::VXLAN_FLAGS;
      6'd46: hdr_byte = net_id[23:16];
      6'd47: hdr_byte = net_id[15:8];
      6'd48: hdr_byte = net_id[7:0];
      6'd50: hdr_byte = head_window[0];
      6'd51: hdr_byte = head_window[1];
      6'd52: hdr_byte = head_window[2];
      6'd53: hdr_byte = head_window[3];
      6'd54: hdr_byte = head_window[4];
      6'd55: hdr_byte = head_window[5];
      6'd56: hdr_byte = head_window[6];
      6'd57: hdr_byte = head_window[7];
      6'd58: hdr_byte = head_window[8];
      6'd59: hdr_byte = head_window[9];
      6'd60: hdr_byte = head_window[10];
      6'd61: hdr_byte = head_window[11];
      6'd62: hdr_byte = burst_tag ? head_window[16] : head_window[12];
      6'd63: hdr_byte = burst_tag ? head_window[17] : head_window[13];
      default: hdr_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      burst_active <= 1'b0;
      burst_idx    <= '0;
    end else if (out_free) begin
      out_valid <= 1'b0;
      if (burst_active) begin
        out_valid <= 1'b1;
        burst_idx <= burst_idx + 6'd1;
        if (burst_idx == 6'(vxe_pkg::BURST_BYTES - 1)) burst_active <= 1'b0;
      end else if (res_valid) begin
        out_valid <= 1'b1;
        if (burst_go) begin
          burst_active <= 1'b1;
          burst_idx    <= 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (burst_active) begin
        out_byte  <= hdr_byte;
        out_last  <= (burst_idx == 6'(vxe_pkg::BURST_BYTES - 1)) && burst_last;
        out_error <= 1'b0;
      end else if (res_valid) begin
        out_byte  <= burst_go ? vxe_pkg::BCAST_BYTE : res_byte;
        out_last  <= burst_go ? 1'b0 : res_last;
        out_error <= res_error;
      end
    end
  end

endmodule
